@@ rtl/core/pbo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_pkg: shared types and constants for the PolyBLEP oscillator
// Request/result structs, command/status groups, codes and the sine
// table generator used by the ROM.
// ----------------------------------------------------------------------------
package pbo_pkg;

    localparam int PHASE_BITS       = 32;
    localparam int OUT_FRAC_BITS    = 16;
    localparam int SAMPLE_BITS      = OUT_FRAC_BITS + 4;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int VAL_W            = 34;   // inner signed Q30 values
    localparam int QUO_W            = 30;
    localparam int RND_SHIFT        = 30 - OUT_FRAC_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd2;

    localparam logic [31:0] STEP_RESET = 32'd42949673;

    // Waveform codes
    localparam logic [1:0] WAVE_SAW   = 2'd0;
    localparam logic [1:0] WAVE_PULSE = 2'd1;
    localparam logic [1:0] WAVE_TRI   = 2'd2;

    localparam logic [16:0] SHAPE_ONE = 17'd65536;
    localparam logic [16:0] K_098     = 17'd64225;
    localparam logic [16:0] K_045     = 17'd29491;

    typedef struct packed {
        logic        req_type;
        logic [31:0] sync_phase;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [31:0]                   phase_now;
    } res_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_INIT,
        OP_MUL_A,
        OP_MUL_B,
        OP_DIV_BLEP,
        OP_BLEP_SQ,
        OP_BLEP_ACC,
        OP_PULSE_B,
        OP_DIV_TRI,
        OP_TRI_ACC,
        OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_INIT,
        ST_MUL_A,
        ST_MUL_B,
        ST_BLEP_START,
        ST_BLEP_WAIT,
        ST_BLEP_SQ,
        ST_BLEP_ACC,
        ST_PULSE_B,
        ST_TRI_START,
        ST_TRI_WAIT,
        ST_TRI_ACC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t  op;
        logic blep_sub;   // subtract correction instead of adding
    } cmd_t;

    typedef struct packed {
        logic       is_sync;
        logic [1:0] wave;
        logic       sh_zero;
        logic       blep_none;
        logic       div_busy;
    } status_t;

    // sin(pi*k/2^aw) in Q30, 13th-order Taylor sum, clamped to [0, 1.0]
    function automatic logic [30:0] sine_entry(int unsigned k, int unsigned aw);
        longint unsigned depth;
        longint unsigned v;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        depth = 64'd1 << aw;
        v     = (2 * longint'(k) <= depth) ? longint'(k) : depth - longint'(k);
        x     = (64'd3373259426 * v) >> aw;
        term  = x;
        sum   = longint'(x);
        term  = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum   = sum - longint'(term);
        term  = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum   = sum + longint'(term);
        term  = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum   = sum - longint'(term);
        term  = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum   = sum + longint'(term);
        term  = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum   = sum - longint'(term);
        term  = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum   = sum + longint'(term);
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 << 30))
            sum = 64'sd1 << 30;
        return 31'(sum);
    endfunction

endpackage

@@ rtl/core/polyblep_oscillator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyblep_oscillator_unit: band-limited saw/pulse/triangle oscillator
// Each request returns one Q3.16 sample and advances a Q0.32 phase, or
// loads the phase on a sync request.
//
//   channel | signals                      | moves
//   --------+------------------------------+---------------------------
//   in      | in_valid, in_ready, req      | one request per handshake
//   out     | out_valid, out_ready, res    | one result per request
//   cfg     | cfg_we, cfg_idx, cfg_data    | register write, no wait
//
// Sync requests skip the waveform math. Saw blends in the sine when shaped
// and adds a BLEP correction near its edge; pulse checks both of its edges
// for corrections; triangle uses the divider unless shape is zero. Every
// divider use runs the 30-step restoring divider.
// Reset sets the config registers to their defaults and clears the phase; there is no clearing pass.
// A new request is taken only after the previous result is registered;
// a stalled result holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module polyblep_oscillator_unit
#(
    parameter int SINE_TABLE_DEPTH = pbo_pkg::SINE_TABLE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pbo_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [pbo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pbo_pkg::req_t                  req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pbo_pkg::res_t                  res
);

    pbo_pkg::cmd_t    cmd;
    pbo_pkg::status_t status;

    // sequencer
    pbo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic
    pbo_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req),
        .res      (res),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

@@ rtl/core/pbo_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_div: restoring fraction divider
// Computes floor(num * 2^30 / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pbo_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [32:0]              num,
    input  logic [32:0]              den,
    output logic                     busy,
    output logic [pbo_pkg::QUO_W-1:0] quo
);

    logic [33:0]               rem_reg, rem_next;
    logic [32:0]               den_reg;
    logic [pbo_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic [33:0]               rem_sh;
    logic                      ge;

    // one restoring step
    always_comb
    begin
        rem_sh   = {rem_reg[32:0], 1'b0};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
        quo_next = {quo_reg[pbo_pkg::QUO_W-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(pbo_pkg::QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_reg <= 1'b0;
        end
    end

    // data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/core/pbo_sine_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_sine_rom: half-period sine table
// Q30 entries of sin(pi*k/DEPTH), registered read.
// ----------------------------------------------------------------------------
module pbo_sine_rom
#(
    parameter int DEPTH = pbo_pkg::SINE_TABLE_DEPTH
)
(
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [30:0]              data
);

    localparam int AW = $clog2(DEPTH);

    logic [30:0] rom_w [DEPTH];
    logic [30:0] data_reg;

    // table contents settle at elaboration
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_entry
        assign rom_w[k] = pbo_pkg::sine_entry(k, AW);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

@@ rtl/core/pbo_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_datapath: oscillator arithmetic
// Config registers, phase accumulator, waveform math, BLEP corrections,
// rounding and the result register. Driven one op per cycle.
// ----------------------------------------------------------------------------
module pbo_datapath
#(
    parameter int SINE_TABLE_DEPTH = pbo_pkg::SINE_TABLE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pbo_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [pbo_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  pbo_pkg::req_t                   req,
    output pbo_pkg::res_t                   res,
    input  pbo_pkg::cmd_t                   cmd,
    output pbo_pkg::status_t                status
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int VW = pbo_pkg::VAL_W;
    localparam logic signed [VW-1:0] Q30  = VW'(64'sd1 << 30);
    localparam logic signed [VW-1:0] Q30X3 = VW'(64'sd3 << 30);
    localparam logic signed [VW-1:0] RND  = VW'(64'sd1 << (pbo_pkg::RND_SHIFT - 1));
    localparam logic signed [VW-1:0] SMAX =
        VW'((64'sd1 << (pbo_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [VW-1:0] SMIN = -SMAX - VW'(1);
    localparam logic [32:0] PH_ONE = 33'h1_0000_0000;
    localparam logic [31:0] PH_HALF = 32'h8000_0000;

    // config and state
    logic [1:0]  wave_cfg_reg;
    logic [16:0] shape_cfg_reg;
    logic [31:0] step_cfg_reg;
    logic [31:0] phase_reg;

    // per-item registers
    logic [31:0]          t_reg, dt_reg, sync_reg, pw_reg, s_reg, bt_reg;
    logic [16:0]          sh_reg;
    logic [1:0]           wave_reg;
    logic                 is_sync_reg;
    logic signed [VW-1:0] val_reg;
    logic signed [49:0]   prod_reg;
    logic [29:0]          sq_reg;
    pbo_pkg::res_t        res_reg;

    // combinational
    logic [16:0]          sh_clamp;
    logic [29:0]          t30;
    logic [30:0]          rom_q;
    logic signed [31:0]   sv;
    logic signed [49:0]   mul_a, mul_b;
    logic signed [50:0]   mix;
    logic [33:0]          p098, p045;
    logic                 blep_lo, blep_hi, tri_lo;
    logic                 div_start, div_busy;
    logic [32:0]          div_num, div_den;
    logic [29:0]          quo;
    logic [59:0]          q_sq;
    logic signed [VW-1:0] q2, sqx, blep_val, tri4, init_val, rnd_val;
    logic [31:0]          phase_adv;

    assign sh_clamp = (shape_cfg_reg > pbo_pkg::SHAPE_ONE) ? pbo_pkg::SHAPE_ONE
                                                            : shape_cfg_reg;
    assign t30 = t_reg[31:2];

    // sine ROM, addressed by frac(2t)
    pbo_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom
    (
        .clk  (clk),
        .addr (t_reg[pbo_pkg::PHASE_BITS-2 -: AW]),
        .data (rom_q)
    );

    // blend multipliers
    assign sv    = t_reg[31] ? $signed({1'b0, rom_q}) : -$signed({1'b0, rom_q});
    assign mul_a = $signed({1'b0, pbo_pkg::SHAPE_ONE - sh_reg}) * $signed(val_reg[31:0]);
    assign mul_b = $signed({1'b0, sh_reg}) * sv;
    assign mix   = 51'(prod_reg) + 51'(mul_b);

    // pulse width and triangle apex
    assign p098 = sh_reg * pbo_pkg::K_098;
    assign p045 = sh_reg * pbo_pkg::K_045;

    // BLEP region and divider operands
    assign blep_lo = bt_reg < dt_reg;
    assign blep_hi = ({1'b0, bt_reg} + {1'b0, dt_reg}) > PH_ONE;
    assign tri_lo  = t_reg < s_reg;

    always_comb
    begin
        div_start = (cmd.op == pbo_pkg::OP_DIV_BLEP) || (cmd.op == pbo_pkg::OP_DIV_TRI);
        if (cmd.op == pbo_pkg::OP_DIV_TRI)
        begin
            div_num = tri_lo ? {1'b0, t_reg} : {1'b0, t_reg - s_reg};
            div_den = tri_lo ? {1'b0, s_reg} : PH_ONE - {1'b0, s_reg};
        end
        else
        begin
            div_num = blep_lo ? {1'b0, bt_reg} : PH_ONE - {1'b0, bt_reg};
            div_den = {1'b0, dt_reg};
        end
    end

    pbo_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (quo)
    );

    // BLEP polynomial
    assign q_sq     = quo * quo;
    assign q2       = $signed({3'b000, quo, 1'b0});
    assign sqx      = $signed({4'b0000, sq_reg});
    assign blep_val = blep_lo ? q2 - sqx - Q30 : sqx - q2 + Q30;

    // initial waveform value
    assign tri4 = $signed({2'b00, t30, 2'b00});
    always_comb
    begin
        unique case (wave_reg)
            pbo_pkg::WAVE_SAW:   init_val = $signed({3'b000, t30, 1'b0}) - Q30;
            pbo_pkg::WAVE_PULSE: init_val = (t_reg < pw_reg) ? Q30 : -Q30;
            pbo_pkg::WAVE_TRI:
                if (sh_reg == 17'd0)
                    init_val = t_reg[31] ? Q30X3 - tri4 : tri4 - Q30;
                else
                    init_val = '0;
            default:             init_val = '0;
        endcase
    end

    // rounding and saturation
    always_comb
    begin
        rnd_val = (val_reg + RND) >>> pbo_pkg::RND_SHIFT;
        if (rnd_val > SMAX)
            rnd_val = SMAX;
        else if (rnd_val < SMIN)
            rnd_val = SMIN;
    end
    assign phase_adv = t_reg + dt_reg;

    // config registers and phase accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_cfg_reg  <= pbo_pkg::WAVE_SAW;
            shape_cfg_reg <= '0;
            step_cfg_reg  <= pbo_pkg::STEP_RESET;
            phase_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    pbo_pkg::CFG_WAVEFORM: wave_cfg_reg  <= cfg_data[1:0];
                    pbo_pkg::CFG_SHAPE:    shape_cfg_reg <= cfg_data[16:0];
                    pbo_pkg::CFG_STEP:     step_cfg_reg  <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.op == pbo_pkg::OP_FINISH)
                phase_reg <= is_sync_reg ? sync_reg : phase_adv;
        end
    end

    // per-item datapath
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            pbo_pkg::OP_LOAD:
            begin
                t_reg       <= phase_reg;
                dt_reg      <= step_cfg_reg;
                sh_reg      <= sh_clamp;
                wave_reg    <= wave_cfg_reg;
                sync_reg    <= req.sync_phase;
                is_sync_reg <= req.req_type;
            end
            pbo_pkg::OP_PREP:
            begin
                pw_reg <= PH_HALF - 32'(p098 >> 1);
                s_reg  <= PH_HALF + 32'(p045);
            end
            pbo_pkg::OP_INIT:
            begin
                val_reg <= init_val;
                bt_reg  <= t_reg;
            end
            pbo_pkg::OP_MUL_A:    prod_reg <= mul_a;
            pbo_pkg::OP_MUL_B:    val_reg  <= VW'(mix >>> 16);
            pbo_pkg::OP_BLEP_SQ:  sq_reg   <= 30'(q_sq >> 30);
            pbo_pkg::OP_BLEP_ACC:
                val_reg <= cmd.blep_sub ? val_reg - blep_val : val_reg + blep_val;
            pbo_pkg::OP_PULSE_B:  bt_reg   <= t_reg - pw_reg;
            pbo_pkg::OP_TRI_ACC:
                val_reg <= tri_lo ? q2 - Q30 : Q30 - q2;
            pbo_pkg::OP_FINISH:
            begin
                res_reg.sample    <= is_sync_reg ? '0 : pbo_pkg::SAMPLE_BITS'(rnd_val);
                res_reg.phase_now <= is_sync_reg ? sync_reg : phase_adv;
            end
            default: ;
        endcase
    end

    assign res = res_reg;

    assign status.is_sync   = is_sync_reg;
    assign status.wave      = wave_reg;
    assign status.sh_zero   = (sh_reg == 17'd0);
    assign status.blep_none = !blep_lo && !blep_hi;
    assign status.div_busy  = div_busy;

endmodule

@@ rtl/core/pbo_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_ctrl: oscillator sequencer
// Walks each request through the datapath ops and owns both handshakes.
// ----------------------------------------------------------------------------
module pbo_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  pbo_pkg::status_t status,
    output pbo_pkg::cmd_t    cmd
);

    pbo_pkg::state_t state_reg, state_next;
    logic            pass_reg, pass_next;
    logic            oval_reg, oval_next;
    logic            out_free;

    assign out_free = !oval_reg || out_ready;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbo_pkg::ST_IDLE;
            pass_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            oval_reg  <= oval_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        oval_next    = (oval_reg && !out_ready) ? 1'b1 : 1'b0;
        cmd.op       = pbo_pkg::OP_NONE;
        cmd.blep_sub = (status.wave == pbo_pkg::WAVE_SAW) || pass_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            pbo_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = pbo_pkg::OP_LOAD;
                    state_next = pbo_pkg::ST_PREP;
                end
            end
            pbo_pkg::ST_PREP:
            begin
                cmd.op     = pbo_pkg::OP_PREP;
                state_next = status.is_sync ? pbo_pkg::ST_FINISH : pbo_pkg::ST_INIT;
            end
            pbo_pkg::ST_INIT:
            begin
                cmd.op    = pbo_pkg::OP_INIT;
                pass_next = 1'b0;
                unique case (status.wave)
                    pbo_pkg::WAVE_SAW:
                        state_next = status.sh_zero ? pbo_pkg::ST_BLEP_START
                                                    : pbo_pkg::ST_MUL_A;
                    pbo_pkg::WAVE_PULSE: state_next = pbo_pkg::ST_BLEP_START;
                    pbo_pkg::WAVE_TRI:
                        state_next = status.sh_zero ? pbo_pkg::ST_FINISH
                                                    : pbo_pkg::ST_TRI_START;
                    default:             state_next = pbo_pkg::ST_FINISH;
                endcase
            end
            pbo_pkg::ST_MUL_A:
            begin
                cmd.op     = pbo_pkg::OP_MUL_A;
                state_next = pbo_pkg::ST_MUL_B;
            end
            pbo_pkg::ST_MUL_B:
            begin
                cmd.op     = pbo_pkg::OP_MUL_B;
                state_next = pbo_pkg::ST_BLEP_START;
            end
            pbo_pkg::ST_BLEP_START:
            begin
                if (!status.blep_none)
                begin
                    cmd.op     = pbo_pkg::OP_DIV_BLEP;
                    state_next = pbo_pkg::ST_BLEP_WAIT;
                end
                else if (status.wave == pbo_pkg::WAVE_PULSE && !pass_reg)
                    state_next = pbo_pkg::ST_PULSE_B;
                else
                    state_next = pbo_pkg::ST_FINISH;
            end
            pbo_pkg::ST_BLEP_WAIT:
                if (!status.div_busy)
                    state_next = pbo_pkg::ST_BLEP_SQ;
            pbo_pkg::ST_BLEP_SQ:
            begin
                cmd.op     = pbo_pkg::OP_BLEP_SQ;
                state_next = pbo_pkg::ST_BLEP_ACC;
            end
            pbo_pkg::ST_BLEP_ACC:
            begin
                cmd.op = pbo_pkg::OP_BLEP_ACC;
                if (status.wave == pbo_pkg::WAVE_PULSE && !pass_reg)
                    state_next = pbo_pkg::ST_PULSE_B;
                else
                    state_next = pbo_pkg::ST_FINISH;
            end
            pbo_pkg::ST_PULSE_B:
            begin
                cmd.op     = pbo_pkg::OP_PULSE_B;
                pass_next  = 1'b1;
                state_next = pbo_pkg::ST_BLEP_START;
            end
            pbo_pkg::ST_TRI_START:
            begin
                cmd.op     = pbo_pkg::OP_DIV_TRI;
                state_next = pbo_pkg::ST_TRI_WAIT;
            end
            pbo_pkg::ST_TRI_WAIT:
                if (!status.div_busy)
                    state_next = pbo_pkg::ST_TRI_ACC;
            pbo_pkg::ST_TRI_ACC:
            begin
                cmd.op     = pbo_pkg::OP_TRI_ACC;
                state_next = pbo_pkg::ST_FINISH;
            end
            pbo_pkg::ST_FINISH:
            begin
                // wait for a free result slot
                if (out_free)
                begin
                    cmd.op     = pbo_pkg::OP_FINISH;
                    oval_next  = 1'b1;
                    state_next = pbo_pkg::ST_IDLE;
                end
            end
            default: state_next = pbo_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = oval_reg;

`ifndef SYNTHESIS
    // divider is never restarted mid-run
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pbo_pkg::OP_DIV_BLEP || cmd.op == pbo_pkg::OP_DIV_TRI)
        |-> !status.div_busy)
        else $error("divider started while busy");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pbo_pkg::OP_FINISH) |-> (!oval_reg || out_ready))
        else $error("result overwritten");

    // an accepted request starts its sequence at once
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == pbo_pkg::ST_PREP))
        else $error("accepted request not started");

    // a finished item always raises out_valid
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pbo_pkg::OP_FINISH) |=> out_valid)
        else $error("finished item not presented");
`endif

endmodule

@@ tb/polyblep_oscillator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyblep_oscillator_unit_test: self-checking bench for the oscillator
// Drives sample and sync requests through the valid/ready channels,
// predicts every result with a bit-exact fixed-point oscillator model and
// compares sample and phase in order. Walks saw, pulse and triangle across
// shape and phase-step settings, with random idling on both sides and one
// long output stall.
// ----------------------------------------------------------------------------
module polyblep_oscillator_unit_test;

    localparam longint unsigned PH_ONE    = 64'd1 << 32;
    localparam longint          Q30       = 64'sd1 << 30;
    localparam int              MAX_CYCLES = 2000000;
    localparam int              DEPTH     = pbo_pkg::SINE_TABLE_DEPTH;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [pbo_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pbo_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    pbo_pkg::req_t                  req;
    logic                           out_valid;
    logic                           out_ready;
    pbo_pkg::res_t                  res;

    polyblep_oscillator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // Oscillator state as the bench sees it
    logic [1:0]      osc_wave;
    longint unsigned osc_shape;
    longint unsigned osc_step;
    longint unsigned osc_phase;
    longint unsigned sine_lut [DEPTH];

    pbo_pkg::res_t pending_results [$];
    int     fail_count;
    int     cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_output;
    bit     stress_go;

    // Directed rows: request plus, where obvious, the expected sample
    typedef struct {
        logic        req_type;
        logic [31:0] sync_phase;
        bit          has_sample;
        int          want_sample;
    } stim_row_t;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sine table, own Taylor evaluation
    function automatic void fill_sine_lut();
        longint unsigned v, x, term;
        longint          sum;
        for (int k = 0; k < DEPTH; k++)
        begin
            v    = (2 * k <= DEPTH) ? k : DEPTH - k;
            x    = (64'd3373259426 * v) / DEPTH;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 6; n++)
            begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > Q30)
                sum = Q30;
            sine_lut[k] = sum;
        end
    endfunction

    function automatic longint shr_floor(longint x, int n);
        return x >>> n;
    endfunction

    // floor(num * 2^30 / den), restoring
    function automatic longint div_q30(longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = num;
        for (int i = 0; i < 30; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 1;
            end
        end
        return longint'(q);
    endfunction

    function automatic longint blep_corr(longint unsigned t, longint unsigned dt);
        longint n;
        if (t < dt)
        begin
            n = div_q30(t, dt);
            return 2 * n - ((n * n) >>> 30) - Q30;
        end
        if (t + dt > PH_ONE)
        begin
            n = div_q30(PH_ONE - t, dt);
            return ((n * n) >>> 30) - 2 * n + Q30;
        end
        return 0;
    endfunction

    // Q30 waveform value at phase t
    function automatic longint wave_q30(longint unsigned t, longint unsigned dt,
                                        longint unsigned sh);
        longint          t30, val, sv;
        longint unsigned idx, pw, apex;
        t30 = longint'(t >> 2);
        val = 0;
        case (osc_wave)
            pbo_pkg::WAVE_SAW:
            begin
                val = 2 * t30 - Q30;
                if (sh > 0)
                begin
                    idx = ((((t << 1) % PH_ONE) * DEPTH) >> 32);
                    if (idx >= DEPTH)
                        idx = DEPTH - 1;
                    sv = longint'(sine_lut[idx]);
                    if (t < PH_ONE / 2)
                        sv = -sv;
                    val = shr_floor(longint'(65536 - sh) * val + longint'(sh) * sv, 16);
                end
                val = val - blep_corr(t, dt);
            end
            pbo_pkg::WAVE_PULSE:
            begin
                pw  = (64'd1 << 31) - ((sh * pbo_pkg::K_098) >> 1);
                val = (t < pw) ? Q30 : -Q30;
                val = val + blep_corr(t, dt);
                val = val - blep_corr((t + PH_ONE - pw) % PH_ONE, dt);
            end
            pbo_pkg::WAVE_TRI:
            begin
                if (sh == 0)
                    val = (t < PH_ONE / 2) ? 4 * t30 - Q30 : 3 * Q30 - 4 * t30;
                else
                begin
                    apex = PH_ONE / 2 + sh * pbo_pkg::K_045;
                    if (t < apex)
                        val = 2 * div_q30(t, apex) - Q30;
                    else
                        val = Q30 - 2 * div_q30(t - apex, PH_ONE - apex);
                end
            end
            default:
                val = 0;
        endcase
        return val;
    endfunction

    // Result of one request; advances the bench's phase
    function automatic pbo_pkg::res_t next_result(pbo_pkg::req_t r);
        pbo_pkg::res_t   o;
        longint          v, s;
        longint unsigned sh;
        s = 0;
        if (r.req_type)
            osc_phase = r.sync_phase;
        else
        begin
            sh = (osc_shape > 65536) ? 65536 : osc_shape;
            v  = wave_q30(osc_phase, osc_step, sh);
            s  = shr_floor(v + (64'sd1 << (pbo_pkg::RND_SHIFT - 1)), pbo_pkg::RND_SHIFT);
            if (s > 524287)
                s = 524287;
            if (s < -524288)
                s = -524288;
            osc_phase = (osc_phase + osc_step) % PH_ONE;
        end
        o.sample    = s[pbo_pkg::SAMPLE_BITS-1:0];
        o.phase_now = osc_phase[31:0];
        return o;
    endfunction

    // Register write at an idle point
    task automatic write_reg(logic [pbo_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            pbo_pkg::CFG_WAVEFORM: osc_wave  = data[1:0];
            pbo_pkg::CFG_SHAPE:    osc_shape = data[16:0];
            pbo_pkg::CFG_STEP:     osc_step  = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // Offer one request and hold it until taken
    task automatic send_req(pbo_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req      <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(next_result(r));
        @(negedge clk);
    endtask

    function automatic pbo_pkg::req_t rand_req();
        pbo_pkg::req_t r;
        r.req_type   = ($urandom_range(9) == 0);
        r.sync_phase = $urandom;
        return r;
    endfunction

    // Output side: sample at rising edge, decide ready at falling edge
    always @(posedge clk)
    begin
        pbo_pkg::res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: sample %0d", res.sample);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, res.sample);
                    fail_count++;
                end
                if (res.phase_now !== want.phase_now)
                begin
                    $error("phase_now: expected %h, got %h", want.phase_now,
                           res.phase_now);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long output stall while requests keep coming
    initial
    begin
        hold_output = 1'b0;
        wait (stress_go);
        @(negedge clk);
        hold_output = 1'b1;
        repeat (800) @(negedge clk);
        hold_output = 1'b0;
    end

    // Random phase across a setting
    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_req(rand_req());
    endtask

    initial
    begin
        stim_row_t     rows [$];
        pbo_pkg::req_t r;
        pbo_pkg::res_t got_ref;
        logic [31:0]   steps [6];
        fail_count    = 0;
        cycle_count   = 0;
        stress_go     = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 47;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = pbo_pkg::CFG_WAVEFORM;
        cfg_data = '0;
        in_valid = 1'b0;
        req      = '0;
        fill_sine_lut();
        osc_wave  = pbo_pkg::WAVE_SAW;
        osc_shape = 0;
        osc_step  = pbo_pkg::STEP_RESET;
        osc_phase = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: defaults after reset, then syncs to phase corners
        rows = '{
            '{1'b0, 32'h0,        1'b1, 0},        // saw at phase 0, BLEP cancels it
            '{1'b0, 32'h0,        1'b0, 0},
            '{1'b1, 32'h8000_0000, 1'b1, 0},       // sync gives zero
            '{1'b0, 32'h0,        1'b0, 0},
            '{1'b1, 32'hFFFF_FFFF, 1'b1, 0},
            '{1'b0, 32'h0,        1'b0, 0},
            '{1'b1, 32'h0,        1'b1, 0},
            '{1'b0, 32'h0,        1'b0, 0}
        };
        foreach (rows[i])
        begin
            r.req_type   = rows[i].req_type;
            r.sync_phase = rows[i].sync_phase;
            send_req(r);
            got_ref = pending_results[$];
            if (rows[i].has_sample && got_ref.sample != rows[i].want_sample)
            begin
                $error("sample: expected %0d, got %0d (table)", rows[i].want_sample,
                       got_ref.sample);
                fail_count++;
            end
        end
        wait_idle();

        // Each waveform, including the unused code, at shape extremes
        for (int w = 0; w < 4; w++)
        begin
            write_reg(pbo_pkg::CFG_WAVEFORM, w);
            for (int s = 0; s < 3; s++)
            begin
                write_reg(pbo_pkg::CFG_SHAPE, (s == 0) ? 0 : (s == 1) ? 65536 : 131071);
                r = '{1'b1, 32'hFFFF_FFF0};
                send_req(r);
                r = '{1'b0, 32'h0};
                send_req(r);
                send_req(r);
                wait_idle();
            end
        end

        // Random phases across settings and idling patterns
        steps = '{32'd1, 32'h8000_0000, pbo_pkg::STEP_RESET, 32'hFFFF_FFFF, 32'd0,
                  32'h0100_0000};
        for (int p = 0; p < 24; p++)
        begin
            if (p == 8)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 30;
            end
            if (p == 16)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(pbo_pkg::CFG_WAVEFORM, (p % 7 == 6) ? pbo_pkg::WAVE_TRI + 1 : p % 3);
            write_reg(pbo_pkg::CFG_SHAPE, (p % 4 == 0) ? 0 : (p % 4 == 1) ? 65536 :
                      $urandom_range(131071));
            write_reg(pbo_pkg::CFG_STEP, (p < 6) ? steps[p] : ($urandom >> $urandom_range(31)));
            if (p == 2)
                stress_go = 1'b1;
            run_random(32);
            wait_idle();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
